// ===== sv/acc_cpu_pkg.sv =====
// Shared types, codes and helpers of the accumulator CPU execute block.
// Depends on nothing; every other file of the block but acc_cpu_ram imports it.
package acc_cpu_pkg;

    localparam int unsigned DATA_W            = 8;
    localparam int unsigned CMD_W             = 2;
    localparam int unsigned DEFAULT_MEM_DEPTH = 256;

    typedef logic [DATA_W-1:0] byte_t;

    // command codes
    localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_EXEC    = 2'd2;
    localparam logic [CMD_W-1:0] CMD_RESTART = 2'd3;

    // opcodes; every other byte is a no-op
    localparam byte_t OP_NOP = 8'd0;
    localparam byte_t OP_STA = 8'd1;
    localparam byte_t OP_LDA = 8'd2;
    localparam byte_t OP_ADD = 8'd3;
    localparam byte_t OP_OR  = 8'd4;
    localparam byte_t OP_AND = 8'd5;
    localparam byte_t OP_NOT = 8'd6;
    localparam byte_t OP_JMP = 8'd8;
    localparam byte_t OP_JN  = 8'd9;
    localparam byte_t OP_JZ  = 8'd10;
    localparam byte_t OP_HLT = 8'd15;

    localparam byte_t HALT_PC = 8'd255;

    // architectural state of the machine
    typedef struct packed {
        byte_t acc;
        logic  neg;
        logic  zero;
        byte_t pc;
        logic  halt;
    } arch_t;

    // one result transaction
    typedef struct packed {
        byte_t read_data;
        byte_t accumulator_out;
        byte_t pc_out;
        logic  negative_out;
        logic  zero_out;
        logic  halted_out;
    } rsp_item_t;

    // byte address modulo the memory depth; the quotient is below 16 for
    // depths of 16 and up, so four restoring steps settle it
    function automatic byte_t wrap_addr(input byte_t a, input int unsigned depth);
        logic [11:0] r;
        r = {4'd0, a};
        for (int k = 3; k >= 0; k--)
        begin
            if (r >= 12'(depth << k))
            begin
                r = r - 12'(depth << k);
            end
        end
        return r[DATA_W-1:0];
    endfunction

    function automatic logic is_two_byte(input byte_t op);
        return (op == OP_STA) || (op == OP_LDA) || (op == OP_ADD) || (op == OP_OR) ||
               (op == OP_AND) || (op == OP_JMP) || (op == OP_JN) || (op == OP_JZ);
    endfunction

endpackage

// ===== sv/acc_cpu_if.sv =====
// Valid/ready channel interfaces: command transactions in, result transactions out.
// Depends on acc_cpu_pkg for the field widths.
interface acc_cpu_cmd_if;
    import acc_cpu_pkg::*;

    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] command;
    byte_t            address;
    byte_t            write_data;

    modport source (output valid, command, address, write_data, input ready);
    modport sink   (input valid, command, address, write_data, output ready);
endinterface

interface acc_cpu_rsp_if;
    import acc_cpu_pkg::*;

    logic  valid;
    logic  ready;
    byte_t read_data;
    byte_t accumulator_out;
    byte_t pc_out;
    logic  negative_out;
    logic  zero_out;
    logic  halted_out;

    modport source (output valid, read_data, accumulator_out, pc_out, negative_out,
                    zero_out, halted_out, input ready);
    modport sink   (input valid, read_data, accumulator_out, pc_out, negative_out,
                    zero_out, halted_out, output ready);
endinterface

// ===== sv/acc_cpu_ram.sv =====
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
module acc_cpu_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem_reg[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem_reg[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/acc_cpu_alu.sv =====
// Instruction execution: next accumulator, flags, pc and halt state for one opcode.
// Depends on acc_cpu_pkg.
module acc_cpu_alu (
    input  acc_cpu_pkg::byte_t op,
    input  acc_cpu_pkg::byte_t ea,
    input  acc_cpu_pkg::byte_t operand,
    input  acc_cpu_pkg::arch_t cur,
    output acc_cpu_pkg::arch_t nxt
);
    import acc_cpu_pkg::*;

    byte_t pc1;
    byte_t pc2;
    byte_t acc_val;
    logic  acc_wr;

    assign pc1 = cur.pc + 8'd1;
    assign pc2 = cur.pc + 8'd2;

    always_comb
    begin
        nxt     = cur;
        acc_wr  = 1'b0;
        acc_val = cur.acc;
        unique case (op)
            OP_STA: nxt.pc = pc2;
            OP_LDA:
            begin
                acc_wr  = 1'b1;
                acc_val = operand;
                nxt.pc  = pc2;
            end
            OP_ADD:
            begin
                acc_wr  = 1'b1;
                acc_val = cur.acc + operand;
                nxt.pc  = pc2;
            end
            OP_OR:
            begin
                acc_wr  = 1'b1;
                acc_val = cur.acc | operand;
                nxt.pc  = pc2;
            end
            OP_AND:
            begin
                acc_wr  = 1'b1;
                acc_val = cur.acc & operand;
                nxt.pc  = pc2;
            end
            OP_NOT:
            begin
                acc_wr  = 1'b1;
                acc_val = ~cur.acc;
                nxt.pc  = pc1;
            end
            OP_JMP: nxt.pc = ea;
            OP_JN:  nxt.pc = cur.neg ? ea : pc2;
            OP_JZ:  nxt.pc = cur.zero ? ea : pc2;
            OP_HLT:
            begin
                nxt.pc   = HALT_PC;
                nxt.halt = 1'b1;
            end
            default: nxt.pc = pc1;
        endcase
        // recompute flags on every accumulator change
        if (acc_wr)
        begin
            nxt.acc  = acc_val;
            nxt.neg  = acc_val[DATA_W-1];
            nxt.zero = (acc_val == '0);
        end
    end

endmodule

// ===== sv/accumulator_cpu_execute_top.sv =====
// Accumulator CPU execute block: sequencer, architectural registers, result register.
// Depends on acc_cpu_pkg, acc_cpu_if, acc_cpu_ram and acc_cpu_alu.
//
// Usage:
//   cmd carries one command per transaction: write memory, read memory,
//   execute one instruction, restart at start_address. rsp returns exactly
//   one result transaction per command: read byte (zero unless read), then
//   accumulator, pc, N, Z and halted as they stand after the command.
//   cfg_we/cfg_wdata write start_address; write it only while idle.
//   Sequencer states from acceptance to the result, with the receiver ready:
//     write, restart, execute while halted: none, result from S_IDLE
//     read: S_READ; one-byte instructions (NOP, NOT, HLT, unused codes): S_OP
//     STA, JMP, JN, JZ: S_OP, S_EA
//     LDA, ADD, OR, AND: S_OP, S_EA, S_OPND
//   Every memory access goes through one single-port RAM, one access a
//   cycle; the opcode, address byte and operand reads each take their own state.
//   A new command is accepted the cycle after the previous result is
//   loaded; the block takes no new command while one is in progress.
//   The result register decouples the sides: while a result waits, the next
//   command runs up to its own result and holds there until rsp drains.
//   After reset the RAM is cleared, one entry a cycle, through every
//   address before cmd.ready rises; cfg writes are taken during that pass.
module accumulator_cpu_execute_top #(
    parameter int unsigned MEM_DEPTH = acc_cpu_pkg::DEFAULT_MEM_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    acc_cpu_cmd_if.sink         cmd,
    acc_cpu_rsp_if.source       rsp,
    input  logic                cfg_we,
    input  acc_cpu_pkg::byte_t  cfg_wdata
);
    import acc_cpu_pkg::*;

    localparam int unsigned AW = $clog2(MEM_DEPTH);

    // sequencer states
    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_READ = 3'd2;
    localparam logic [2:0] S_OP   = 3'd3;
    localparam logic [2:0] S_EA   = 3'd4;
    localparam logic [2:0] S_OPND = 3'd5;
    localparam logic [2:0] S_HOLD = 3'd6;

    logic [2:0]    state_reg, state_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    arch_t         arch_reg, arch_next;
    byte_t         start_reg;
    byte_t         op_reg, op_next;
    byte_t         ea_reg, ea_next;
    byte_t         hold_rd_reg, hold_rd_next;
    logic          out_valid_reg, out_valid_next;
    rsp_item_t     out_reg, out_next;

    logic          ram_en;
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    byte_t         ram_wdata;
    byte_t         ram_rdata;

    byte_t         alu_op;
    byte_t         alu_ea;
    arch_t         alu_nxt;

    logic          accept;
    logic          out_free;
    logic          emit;
    byte_t         emit_rd;
    logic          load_out;

    acc_cpu_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MEM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // opcode and address byte come straight off the RAM in the cycle they arrive
    assign alu_op = (state_reg == S_OP) ? ram_rdata : op_reg;
    assign alu_ea = (state_reg == S_EA) ? ram_rdata : ea_reg;

    acc_cpu_alu u_alu (
        .op      (alu_op),
        .ea      (alu_ea),
        .operand (ram_rdata),
        .cur     (arch_reg),
        .nxt     (alu_nxt)
    );

    assign cmd.ready = (state_reg == S_IDLE);
    assign accept    = cmd.valid && cmd.ready;
    assign out_free  = !out_valid_reg || rsp.ready;

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        arch_next    = arch_reg;
        op_next      = op_reg;
        ea_next      = ea_reg;
        ram_en       = 1'b0;
        ram_we       = 1'b0;
        ram_addr     = '0;
        ram_wdata    = '0;
        emit         = 1'b0;
        emit_rd      = '0;

        unique case (state_reg)
            S_CLR:
            begin
                // sweep zeros through the memory
                ram_en   = 1'b1;
                ram_we   = 1'b1;
                ram_addr = clr_cnt_reg;
                if (clr_cnt_reg == AW'(MEM_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd.command)
                        CMD_WRITE:
                        begin
                            ram_en    = 1'b1;
                            ram_we    = 1'b1;
                            ram_addr  = AW'(wrap_addr(cmd.address, MEM_DEPTH));
                            ram_wdata = cmd.write_data;
                            emit      = 1'b1;
                        end
                        CMD_READ:
                        begin
                            ram_en     = 1'b1;
                            ram_addr   = AW'(wrap_addr(cmd.address, MEM_DEPTH));
                            state_next = S_READ;
                        end
                        CMD_EXEC:
                        begin
                            if (arch_reg.halt)
                            begin
                                emit = 1'b1;
                            end
                            else
                            begin
                                // fetch the opcode
                                ram_en     = 1'b1;
                                ram_addr   = AW'(wrap_addr(arch_reg.pc, MEM_DEPTH));
                                state_next = S_OP;
                            end
                        end
                        CMD_RESTART:
                        begin
                            arch_next.pc   = start_reg;
                            arch_next.halt = 1'b0;
                            emit           = 1'b1;
                        end
                        default: emit = 1'b1;
                    endcase
                end
            end
            S_READ:
            begin
                emit    = 1'b1;
                emit_rd = ram_rdata;
            end
            S_OP:
            begin
                op_next = ram_rdata;
                if (is_two_byte(ram_rdata))
                begin
                    // fetch the address byte
                    ram_en     = 1'b1;
                    ram_addr   = AW'(wrap_addr(arch_reg.pc + 8'd1, MEM_DEPTH));
                    state_next = S_EA;
                end
                else
                begin
                    arch_next = alu_nxt;
                    emit      = 1'b1;
                end
            end
            S_EA:
            begin
                ea_next = ram_rdata;
                case (op_reg) inside
                    OP_LDA, OP_ADD, OP_OR, OP_AND:
                    begin
                        // fetch the operand
                        ram_en     = 1'b1;
                        ram_addr   = AW'(wrap_addr(ram_rdata, MEM_DEPTH));
                        state_next = S_OPND;
                    end
                    OP_STA:
                    begin
                        ram_en    = 1'b1;
                        ram_we    = 1'b1;
                        ram_addr  = AW'(wrap_addr(ram_rdata, MEM_DEPTH));
                        ram_wdata = arch_reg.acc;
                        arch_next = alu_nxt;
                        emit      = 1'b1;
                    end
                    default:
                    begin
                        arch_next = alu_nxt;
                        emit      = 1'b1;
                    end
                endcase
            end
            S_OPND:
            begin
                arch_next = alu_nxt;
                emit      = 1'b1;
            end
            S_HOLD:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        // commit now; park the result if the output register is still full
        if (emit)
        begin
            state_next = out_free ? S_IDLE : S_HOLD;
        end
    end

    assign hold_rd_next = emit ? emit_rd : hold_rd_reg;
    assign load_out     = out_free && (emit || (state_reg == S_HOLD));

    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            if (emit)
            begin
                out_next.read_data       = emit_rd;
                out_next.accumulator_out = arch_next.acc;
                out_next.pc_out          = arch_next.pc;
                out_next.negative_out    = arch_next.neg;
                out_next.zero_out        = arch_next.zero;
                out_next.halted_out      = arch_next.halt;
            end
            else
            begin
                out_next.read_data       = hold_rd_reg;
                out_next.accumulator_out = arch_reg.acc;
                out_next.pc_out          = arch_reg.pc;
                out_next.negative_out    = arch_reg.neg;
                out_next.zero_out        = arch_reg.zero;
                out_next.halted_out      = arch_reg.halt;
            end
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_cnt_reg   <= '0;
            arch_reg      <= '{acc: '0, neg: 1'b0, zero: 1'b1, pc: '0, halt: 1'b0};
            start_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            arch_reg      <= arch_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                start_reg <= cfg_wdata;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        ea_reg      <= ea_next;
        hold_rd_reg <= hold_rd_next;
        out_reg     <= out_next;
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.read_data       = out_reg.read_data;
    assign rsp.accumulator_out = out_reg.accumulator_out;
    assign rsp.pc_out          = out_reg.pc_out;
    assign rsp.negative_out    = out_reg.negative_out;
    assign rsp.zero_out        = out_reg.zero_out;
    assign rsp.halted_out      = out_reg.halted_out;

    // a halted machine parks its pc at HALT_PC, the top byte address
    a_halt_pc: assert property (@(posedge clk) disable iff (!rst_n)
        arch_reg.halt |-> (arch_reg.pc == HALT_PC))
        else $error("halted with pc off the halt address");

    // flags always track the accumulator
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (arch_reg.zero == (arch_reg.acc == '0)) && (arch_reg.neg == arch_reg.acc[DATA_W-1]))
        else $error("N/Z flags out of step with accumulator");

    // a parked result only exists behind a full output register
    a_hold_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_HOLD) |-> out_valid_reg)
        else $error("result parked while output register is empty");

endmodule

// ===== tb/accumulator_cpu_execute_checker.sv =====
// Result checker for the accumulator CPU execute block: mirrors the machine state,
// predicts one result per accepted command and compares it with the rsp channel.
// Depends on acc_cpu_pkg and the channel interfaces in acc_cpu_if.
`timescale 1ns / 100ps

module accumulator_cpu_execute_checker #(
    parameter int unsigned MEM_DEPTH = acc_cpu_pkg::DEFAULT_MEM_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    acc_cpu_cmd_if              cmd,
    acc_cpu_rsp_if              rsp,
    input  logic                cfg_we,
    input  acc_cpu_pkg::byte_t  cfg_wdata,
    output int unsigned         fail_count,
    output int unsigned         pending_count
);
    import acc_cpu_pkg::*;

    byte_t      mem_model [MEM_DEPTH];
    arch_t      cpu;
    byte_t      start_addr;
    rsp_item_t  pending_results [$];
    rsp_item_t  want;

    function automatic int unsigned mem_idx(input byte_t a);
        return int'(a) % MEM_DEPTH;
    endfunction

    // load the accumulator and refresh N and Z
    function automatic void set_accumulator(input byte_t v);
        cpu.acc  = v;
        cpu.neg  = v[DATA_W-1];
        cpu.zero = (v == '0);
    endfunction

    function automatic void step_instruction();
        byte_t op;
        byte_t ea;
        byte_t operand;
        byte_t next1;
        byte_t next2;
        op      = mem_model[mem_idx(cpu.pc)];
        next1   = cpu.pc + 8'd1;
        next2   = cpu.pc + 8'd2;
        ea      = mem_model[mem_idx(next1)];
        operand = mem_model[mem_idx(ea)];
        case (op)
            OP_STA:
            begin
                mem_model[mem_idx(ea)] = cpu.acc;
                cpu.pc = next2;
            end
            OP_LDA:
            begin
                set_accumulator(operand);
                cpu.pc = next2;
            end
            OP_ADD:
            begin
                set_accumulator(cpu.acc + operand);
                cpu.pc = next2;
            end
            OP_OR:
            begin
                set_accumulator(cpu.acc | operand);
                cpu.pc = next2;
            end
            OP_AND:
            begin
                set_accumulator(cpu.acc & operand);
                cpu.pc = next2;
            end
            OP_NOT:
            begin
                set_accumulator(~cpu.acc);
                cpu.pc = next1;
            end
            OP_JMP: cpu.pc = ea;
            OP_JN:  cpu.pc = cpu.neg ? ea : next2;
            OP_JZ:  cpu.pc = cpu.zero ? ea : next2;
            OP_HLT:
            begin
                cpu.pc   = HALT_PC;
                cpu.halt = 1'b1;
            end
            default: cpu.pc = next1;
        endcase
    endfunction

    function automatic rsp_item_t execute_command(input logic [CMD_W-1:0] c,
                                                  input byte_t a, input byte_t d);
        rsp_item_t res;
        res.read_data = '0;
        case (c)
            CMD_WRITE:   mem_model[mem_idx(a)] = d;
            CMD_READ:    res.read_data = mem_model[mem_idx(a)];
            CMD_EXEC:
            begin
                if (!cpu.halt)
                begin
                    step_instruction();
                end
            end
            default:
            begin
                cpu.pc   = start_addr;
                cpu.halt = 1'b0;
            end
        endcase
        res.accumulator_out = cpu.acc;
        res.pc_out          = cpu.pc;
        res.negative_out    = cpu.neg;
        res.zero_out        = cpu.zero;
        res.halted_out      = cpu.halt;
        return res;
    endfunction

    function automatic void compare_field(input string name, input int unsigned exp_v,
                                          input int unsigned act_v);
        if (exp_v != act_v)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MEM_DEPTH; i++)
            begin
                mem_model[i] = '0;
            end
            cpu.acc    = '0;
            cpu.neg    = 1'b0;
            cpu.zero   = 1'b1;
            cpu.pc     = '0;
            cpu.halt   = 1'b0;
            start_addr = '0;
            pending_results.delete();
            fail_count    = 0;
            pending_count <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                start_addr = cfg_wdata;
            end
            if (cmd.valid && cmd.ready)
            begin
                pending_results.push_back(execute_command(cmd.command, cmd.address,
                                                          cmd.write_data));
            end
            if (rsp.valid && rsp.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result transaction with no command outstanding");
                    fail_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    compare_field("read_data", want.read_data, rsp.read_data);
                    compare_field("accumulator_out", want.accumulator_out,
                                  rsp.accumulator_out);
                    compare_field("pc_out", want.pc_out, rsp.pc_out);
                    compare_field("negative_out", want.negative_out, rsp.negative_out);
                    compare_field("zero_out", want.zero_out, rsp.zero_out);
                    compare_field("halted_out", want.halted_out, rsp.halted_out);
                end
            end
            pending_count <= pending_results.size();
        end
    end

endmodule

// ===== tb/accumulator_cpu_execute_top_tb.sv =====
// Top of the accumulator CPU execute testbench: clock, reset, command stimulus,
// start_address writes and the verdict; checking lives in accumulator_cpu_execute_checker.
// Depends on acc_cpu_pkg, acc_cpu_if, the block and the checker.
`timescale 1ns / 100ps

module accumulator_cpu_execute_top_tb;
    import acc_cpu_pkg::*;

    localparam int unsigned MEM_DEPTH     = DEFAULT_MEM_DEPTH;
    localparam int unsigned ITEM_TARGET   = 700;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned IDLE_PCT      = 11;
    localparam byte_t       DATA_OFFSET   = 8'h80; // operand area relative to the program

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    byte_t       cfg_wdata;
    logic        idle_on;
    int unsigned fail_count;
    int unsigned pending_count;
    int unsigned sent_count;

    acc_cpu_cmd_if cmd_ch ();
    acc_cpu_rsp_if rsp_ch ();

    accumulator_cpu_execute_top #(
        .MEM_DEPTH (MEM_DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    accumulator_cpu_execute_checker #(
        .MEM_DEPTH (MEM_DEPTH)
    ) u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd_ch),
        .rsp           (rsp_ch),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // 2 ns clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop in case the handshake locks up.
    initial
    begin
        #1_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Receiver: drop ready at random, with an IDLE_PCT (11) percent chance, while
    // idling is enabled, hold it high throughout the stretches without idling.
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            rsp_ch.ready <= !(idle_on && ($urandom_range(0, 99) < IDLE_PCT));
        end
    end

    // Byte biased toward the arithmetic corners: zero, sign bit, all ones, 0x7F.
    function automatic byte_t pick_data();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'h80;
            2:       return 8'hFF;
            3:       return 8'h7F;
            default: return byte_t'($urandom);
        endcase
    endfunction

    // Offer one command transaction and hold it until accepted. Random gaps
    // drop valid before the offer; valid stays high across back-to-back sends.
    task automatic send_cmd(input logic [CMD_W-1:0] c, input byte_t a, input byte_t d);
        while (idle_on && ($urandom_range(0, 99) < IDLE_PCT))
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid      <= 1'b1;
        cmd_ch.command    <= c;
        cmd_ch.address    <= a;
        cmd_ch.write_data <= d;
        do @(posedge clk); while (!cmd_ch.ready);
        sent_count++;
    endtask

    // Stop offering and wait for every outstanding result to come back.
    task automatic wait_drained();
        cmd_ch.valid <= 1'b0;
        do @(posedge clk); while (pending_count != 0);
    endtask

    task automatic write_start(input byte_t v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Write a random well-formed program at base, with its operand area at
    // base + DATA_OFFSET and jump targets within 2 * n_instr bytes of base.
    task automatic load_program(input byte_t base);
        byte_t       loc;
        byte_t       op;
        byte_t       data_base;
        int unsigned n_instr;
        int unsigned r;
        logic        two_byte;
        logic        is_jump;
        n_instr   = $urandom_range(6, 14);
        data_base = base + DATA_OFFSET;
        for (int i = 0; i < 8; i++)
        begin
            send_cmd(CMD_WRITE, data_base + byte_t'(i), pick_data());
        end
        loc = base;
        for (int i = 0; i < n_instr; i++)
        begin
            r        = $urandom_range(0, 99);
            two_byte = 1'b1;
            is_jump  = 1'b0;
            if (r < 12)      op = OP_LDA;
            else if (r < 24) op = OP_ADD;
            else if (r < 32) op = OP_OR;
            else if (r < 40) op = OP_AND;
            else if (r < 48) op = OP_STA;
            else if (r < 54) begin op = OP_JMP; is_jump = 1'b1; end
            else if (r < 64) begin op = OP_JN;  is_jump = 1'b1; end
            else if (r < 74) begin op = OP_JZ;  is_jump = 1'b1; end
            else
            begin
                two_byte = 1'b0;
                if (r < 82)      op = OP_NOT;
                else if (r < 86) op = OP_NOP;
                else if (r < 90) op = OP_NOT + 8'd1;
                else if (r < 93) op = OP_JZ + byte_t'($urandom_range(1, 4));
                else if (r < 96) op = OP_HLT + byte_t'($urandom_range(1, 240));
                else             op = OP_HLT;
            end
            send_cmd(CMD_WRITE, loc, op);
            loc++;
            if (two_byte)
            begin
                if (is_jump)
                    send_cmd(CMD_WRITE, loc, base + byte_t'($urandom_range(0, 2 * n_instr - 1)));
                else
                    send_cmd(CMD_WRITE, loc, data_base + byte_t'($urandom_range(0, 7)));
                loc++;
            end
        end
    endtask

    // One phase: idle pause, new start_address, fresh program, then mostly
    // execute commands with reads, restarts and random noise mixed in.
    task automatic run_phase(input byte_t start, input int unsigned n_steps);
        int unsigned r;
        wait_drained();
        write_start(start);
        load_program(start);
        send_cmd(CMD_RESTART, byte_t'($urandom), byte_t'($urandom));
        for (int i = 0; i < n_steps; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 75)
                send_cmd(CMD_EXEC, byte_t'($urandom), byte_t'($urandom));
            else if (r < 85)
                send_cmd(CMD_READ, start + DATA_OFFSET + byte_t'($urandom_range(0, 7)),
                         byte_t'($urandom));
            else if (r < 88)
                send_cmd(CMD_READ, byte_t'($urandom), byte_t'($urandom));
            else if (r < 93)
                send_cmd(CMD_RESTART, byte_t'($urandom), byte_t'($urandom));
            else
                send_cmd(CMD_W'($urandom_range(0, 3)), byte_t'($urandom), pick_data());
        end
    endtask

    initial
    begin
        byte_t       start;
        int unsigned phase;

        rst_n             = 1'b0;
        idle_on           = 1'b1;
        sent_count        = 0;
        cfg_we            = 1'b0;
        cfg_wdata         = '0;
        cmd_ch.valid      = 1'b0;
        cmd_ch.command    = CMD_READ;
        cmd_ch.address    = '0;
        cmd_ch.write_data = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: start_address at its top value, taken during the clearing pass.
        write_start(8'hFF);
        send_cmd(CMD_READ, 8'h00, 8'h00);          // cleared memory reads zero
        send_cmd(CMD_WRITE, 8'hFF, 8'hFF);
        send_cmd(CMD_READ, 8'hFF, 8'h00);
        send_cmd(CMD_RESTART, 8'h00, 8'h00);       // pc to 255
        send_cmd(CMD_EXEC, 8'h00, 8'h00);          // unused code at 255, pc wraps to 0

        // Pause until idle, then drop start_address back to zero.
        wait_drained();
        write_start(8'h00);
        send_cmd(CMD_WRITE, 8'hFE, 8'h80);
        send_cmd(CMD_WRITE, 8'h00, OP_LDA);
        send_cmd(CMD_WRITE, 8'h01, 8'hFE);
        send_cmd(CMD_WRITE, 8'h02, OP_ADD);
        send_cmd(CMD_WRITE, 8'h03, 8'hFE);
        send_cmd(CMD_WRITE, 8'h04, OP_NOT);
        send_cmd(CMD_WRITE, 8'h05, OP_NOT + 8'd1);
        send_cmd(CMD_WRITE, 8'h06, OP_HLT);
        send_cmd(CMD_RESTART, 8'h00, 8'h00);
        send_cmd(CMD_EXEC, 8'h00, 8'h00);          // load 0x80, N set
        send_cmd(CMD_EXEC, 8'h00, 8'h00);          // 0x80 + 0x80 wraps to zero, Z set
        send_cmd(CMD_EXEC, 8'h00, 8'h00);          // invert to 0xFF
        send_cmd(CMD_EXEC, 8'h00, 8'h00);          // unused code advances by one
        send_cmd(CMD_EXEC, 8'h00, 8'h00);          // halt, pc to 255
        send_cmd(CMD_EXEC, 8'h00, 8'h00);          // halted: nothing moves
        send_cmd(CMD_READ, 8'hFE, 8'h00);
        send_cmd(CMD_RESTART, 8'h00, 8'h00);       // clears halted, keeps flags

        // Random programs; phases 3 and 4 run with no idling on either side.
        phase = 0;
        while (sent_count < ITEM_TARGET)
        begin
            case (phase)
                0:       start = 8'h00;
                1:       start = 8'hFF;
                2:       start = 8'hF8;
                default: start = byte_t'($urandom);
            endcase
            idle_on = !((phase == 3) || (phase == 4));
            run_phase(start, $urandom_range(20, 40));
            phase++;
        end

        // Drain, let the pipeline settle, then give the verdict.
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if ((fail_count == 0) && (pending_count == 0))
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
